FILE: rtl/bels_pkg.sv
// ----------------------------------------------------------------------------
// Big-endian load/store memory package
// Opcodes, widths and shared types for the byte-lane data memory.
// ----------------------------------------------------------------------------
package bels_pkg;

  localparam int unsigned AddrW    = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned LaneBits = 2;
  localparam int unsigned Lanes    = 1 << LaneBits;
  localparam int unsigned RowW     = AddrW - LaneBits;
  localparam int unsigned MemBytes = 1 << AddrW;
  localparam int unsigned RowDepth = MemBytes / Lanes;

  typedef enum logic [2:0] {
    OpLb  = 3'd0,
    OpLbu = 3'd1,
    OpLh  = 3'd2,
    OpLhu = 3'd3,
    OpLw  = 3'd4,
    OpSb  = 3'd5,
    OpSh  = 3'd6,
    OpSw  = 3'd7
  } op_e;

  typedef logic [Lanes-1:0][ByteW-1:0] lane_bytes_t;

  // Control that travels alongside the lane read data.
  typedef struct packed {
    op_e                 opcode;
    logic [LaneBits-1:0] offset;
  } ctrl_t;

  // Index of the last byte touched by an access, counted from the first.
  function automatic logic [LaneBits-1:0] last_byte(input op_e op);
    logic [LaneBits-1:0] last;
    if (op inside {OpLb, OpLbu, OpSb}) begin
      last = '0;
    end else if (op inside {OpLh, OpLhu, OpSh}) begin
      last = LaneBits'(1);
    end else begin
      last = '1;
    end
    return last;
  endfunction

endpackage

FILE: rtl/big_endian_load_store_memory.sv
// ----------------------------------------------------------------------------
// Big-endian load/store memory
// 64 KiB byte-addressed data memory with byte, halfword and word accesses.
// ----------------------------------------------------------------------------
// The block takes one load or store item every cycle while in_stall_o is low
// and returns one result item for each. When the output is not stalled, the
// item moves from the input register through the registered read port of the
// lane RAMs into the result register.
// The memory is split into four byte-wide lane RAMs by
// the low two address bits, so any access of up to four consecutive bytes,
// aligned or not, touches each lane at most once and completes in a single
// pass. Addresses wrap at the end of the memory. Memory contents are
// undefined after reset and no clearing pass is run; loads of bytes that were
// never stored return arbitrary data. Stores return zero.
module big_endian_load_store_memory (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                opcode_i,
  input  logic [bels_pkg::AddrW-1:0] address_i,
  input  logic [bels_pkg::DataW-1:0] store_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [bels_pkg::DataW-1:0] read_data_o
);
  import bels_pkg::*;

  logic s1_v_q, s2_v_q, out_valid_q;
  logic s1_adv, s2_adv, out_adv;

  op_e              s1_op_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [DataW-1:0] s1_data_q;
  ctrl_t            s2_ctrl_q;
  logic [DataW-1:0] result_q;
  logic [DataW-1:0] result;

  logic [Lanes-1:0]            lane_en;
  logic                        s1_store;
  logic [RowW-1:0]             lane_row   [Lanes];
  logic [ByteW-1:0]            lane_wdata [Lanes];
  lane_bytes_t                 lane_rdata;

  // Each stage moves on when it is empty or the stage after it moves.
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s2_adv     = !s2_v_q || out_adv;
  assign s1_adv     = !s1_v_q || s2_adv;
  assign in_stall_o = !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_adv) begin
        s2_v_q <= s1_v_q;
      end
      if (out_adv) begin
        out_valid_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      s1_op_q   <= op_e'(opcode_i);
      s1_addr_q <= address_i;
      s1_data_q <= store_data_i;
    end
    if (s2_adv && s1_v_q) begin
      s2_ctrl_q.opcode <= s1_op_q;
      s2_ctrl_q.offset <= s1_addr_q[LaneBits-1:0];
    end
    if (out_adv && s2_v_q) begin
      result_q <= result;
    end
  end

  assign s1_store = (s1_op_q == OpSb) || (s1_op_q == OpSh) || (s1_op_q == OpSw);

  // Lane l holds byte k = l - offset of the access. Lanes below the start
  // offset belong to the next row.
  always_comb begin
    logic [LaneBits-1:0] k;
    logic [LaneBits-1:0] widx;
    logic [LaneBits-1:0] last;
    last = last_byte(s1_op_q);
    for (int l = 0; l < Lanes; l++) begin
      k = LaneBits'(l) - s1_addr_q[LaneBits-1:0];
      lane_en[l]  = s1_v_q && s2_adv && (k <= last);
      lane_row[l] = s1_addr_q[AddrW-1:LaneBits]
                    + RowW'(LaneBits'(l) < s1_addr_q[LaneBits-1:0]);
      // The first byte stored is the most significant one of the value.
      widx = last - k;
      lane_wdata[l] = s1_data_q[ByteW*widx +: ByteW];
    end
  end

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    bels_lane_ram u_lane_ram (
      .clk_i   (clk_i),
      .en_i    (lane_en[l]),
      .we_i    (s1_store),
      .addr_i  (lane_row[l]),
      .wdata_i (lane_wdata[l]),
      .rdata_o (lane_rdata[l])
    );
  end

  bels_load_align u_load_align (
    .ctrl_i   (s2_ctrl_q),
    .lanes_i  (lane_rdata),
    .result_o (result)
  );

  assign out_valid_o = out_valid_q;
  assign read_data_o = result_q;

  a_lane_span : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s2_adv) |-> ($countones(lane_en) == 1 || $countones(lane_en) == 2 ||
                            $countones(lane_en) == 4))
    else $error("lane enables do not match access size");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_v_q && s2_v_q && out_valid_q && out_stall_i))
    else $error("input stalled while the pipeline has room");

  a_s1_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s2_adv) |=> s2_v_q)
    else $error("item lost between input register and read stage");

  a_s2_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && !s2_adv) |=> (s2_v_q && $stable(s2_ctrl_q)))
    else $error("read stage changed while held");

endmodule

FILE: rtl/bels_lane_ram.sv
// ----------------------------------------------------------------------------
// Byte lane RAM
// One byte-wide lane of the data memory: one read or one write per cycle,
// read data registered.
// ----------------------------------------------------------------------------
module bels_lane_ram (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic                      we_i,
  input  logic [bels_pkg::RowW-1:0]  addr_i,
  input  logic [bels_pkg::ByteW-1:0] wdata_i,
  output logic [bels_pkg::ByteW-1:0] rdata_o
);
  import bels_pkg::*;

  logic [ByteW-1:0] mem [RowDepth];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && !we_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bels_load_align.sv
// ----------------------------------------------------------------------------
// Load alignment
// Rotates the four lane bytes into big-endian order and sign or zero extends
// the loaded value. Stores give zero.
// ----------------------------------------------------------------------------
module bels_load_align (
  input  bels_pkg::ctrl_t            ctrl_i,
  input  bels_pkg::lane_bytes_t      lanes_i,
  output logic [bels_pkg::DataW-1:0] result_o
);
  import bels_pkg::*;

  logic [Lanes-1:0][ByteW-1:0] b;

  // Byte k of the access sits in lane offset + k, modulo the lane count.
  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      b[k] = lanes_i[ctrl_i.offset + LaneBits'(k)];
    end
  end

  always_comb begin
    case (ctrl_i.opcode)
      OpLb:    result_o = {{(DataW - ByteW){b[0][ByteW-1]}}, b[0]};
      OpLbu:   result_o = {{(DataW - ByteW){1'b0}}, b[0]};
      OpLh:    result_o = {{(DataW - 2*ByteW){b[0][ByteW-1]}}, b[0], b[1]};
      OpLhu:   result_o = {{(DataW - 2*ByteW){1'b0}}, b[0], b[1]};
      OpLw:    result_o = {b[0], b[1], b[2], b[3]};
      default: result_o = '0;
    endcase
  end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the big-endian load/store memory
// Drives byte, halfword and word loads and stores through the valid/stall
// ports, keeps a byte image of the memory to predict each read word, and
// checks every result in order under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module tb;
  import bels_pkg::*;

  localparam int unsigned TimeoutUnits = 800000;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [2:0]       opcode_i;
  logic [AddrW-1:0] address_i;
  logic [DataW-1:0] store_data_i;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [DataW-1:0] read_data_o;

  // Byte image of the memory and a record of which bytes hold stored data.
  logic [ByteW-1:0] mem_image [MemBytes];
  bit               byte_written [MemBytes];
  logic [AddrW-1:0] stored_bases [$];
  logic [DataW-1:0] expected_reads [$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned mismatches      = 0;

  big_endian_load_store_memory dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .address_i    (address_i),
    .store_data_i (store_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o)
  );

  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    #(TimeoutUnits);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void store_byte(input logic [AddrW-1:0] addr,
                                     input logic [ByteW-1:0] value);
    mem_image[addr]    = value;
    byte_written[addr] = 1'b1;
  endfunction

  // Applies one access to the byte image and returns the read word it gives.
  function automatic logic [DataW-1:0] predict_access(input op_e op,
                                                      input logic [AddrW-1:0] addr,
                                                      input logic [DataW-1:0] data);
    logic [DataW-1:0] word;
    word = '0;
    case (op)
      OpLb, OpLbu: begin
        word = {24'h0, mem_image[addr]};
        if (op == OpLb && word[7]) word = word | 32'hFFFF_FF00;
      end
      OpLh, OpLhu: begin
        word = {16'h0, mem_image[addr], mem_image[AddrW'(addr + 1)]};
        if (op == OpLh && word[15]) word = word | 32'hFFFF_0000;
      end
      OpLw: begin
        word = {mem_image[addr], mem_image[AddrW'(addr + 1)],
                mem_image[AddrW'(addr + 2)], mem_image[AddrW'(addr + 3)]};
      end
      OpSb: store_byte(addr, data[7:0]);
      OpSh: begin
        store_byte(addr, data[15:8]);
        store_byte(AddrW'(addr + 1), data[7:0]);
      end
      default: begin
        store_byte(addr, data[31:24]);
        store_byte(AddrW'(addr + 1), data[23:16]);
        store_byte(AddrW'(addr + 2), data[15:8]);
        store_byte(AddrW'(addr + 3), data[7:0]);
      end
    endcase
    return word;
  endfunction

  // Sends one item; called and returning just after a falling edge.
  task automatic send_access(input op_e op, input logic [AddrW-1:0] addr,
                             input logic [DataW-1:0] data);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    address_i    <= addr;
    store_data_i <= data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_reads.push_back(predict_access(op, addr, data));
    if (op inside {OpSb, OpSh, OpSw}) begin
      stored_bases.push_back(addr);
      if (stored_bases.size() > 256) void'(stored_bases.pop_front());
    end
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic bit bytes_ready(input op_e op, input logic [AddrW-1:0] addr);
    int unsigned count;
    bit ok;
    count = 32'(last_byte(op)) + 1;
    ok = 1'b1;
    for (int unsigned k = 0; k < count; k++) begin
      if (!byte_written[AddrW'(addr + k)]) ok = 1'b0;
    end
    return ok;
  endfunction

  task automatic pick_access(output op_e op, output logic [AddrW-1:0] addr,
                             output logic [DataW-1:0] data);
    logic [AddrW-1:0] base;
    int unsigned roll;
    roll = $urandom_range(99);
    case ($urandom_range(9))
      0: data = 32'h0000_0000;
      1: data = 32'hFFFF_FFFF;
      2: data = 32'h8080_8080;
      3: data = 32'h7F7F_7F7F;
      default: data = $urandom();
    endcase
    if (stored_bases.size() == 0 || roll < 45) begin
      op = op_e'($urandom_range(OpSb, OpSw));
      case ($urandom_range(4))
        0, 1: addr = AddrW'($urandom());
        2:    addr = AddrW'(16'hFFFC + $urandom_range(7));
        default: begin
          base = stored_bases[$urandom_range(stored_bases.size() - 1)];
          addr = AddrW'(base + $urandom_range(6) - 3);
        end
      endcase
    end else begin
      base = stored_bases[$urandom_range(stored_bases.size() - 1)];
      op   = op_e'($urandom_range(OpLb, OpLw));
      addr = AddrW'(base + $urandom_range(3) - $urandom_range(1));
      // Never load a byte that has not been stored; the base byte always was.
      if (!bytes_ready(op, addr)) begin
        addr = base;
        op   = $urandom_range(1) ? OpLb : OpLbu;
      end
    end
  endtask

  task automatic run_random_accesses(input int unsigned count);
    op_e op;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
    for (int unsigned i = 0; i < count; i++) begin
      pick_access(op, addr, data);
      send_access(op, addr, data);
    end
  endtask

  always @(posedge clk_i) begin
    logic [DataW-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: read_data %h", read_data_o);
      end else begin
        want = expected_reads.pop_front();
        if (read_data_o !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("read_data mismatch: expected %h, actual %h", want, read_data_o);
          end
        end
      end
    end
  end

  task automatic test_directed_corners();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_access(OpSw, 16'h0000, 32'h80FF_7F01);
    send_access(OpSw, 16'hFFFC, 32'hDEAD_BEEF);
    // Word store that runs past the last byte and wraps to byte 0.
    send_access(OpSw, 16'hFFFE, 32'h1234_5678);
    send_access(OpSh, 16'h7FFF, 32'hFFFF_8001);
    send_access(OpSb, 16'h1234, 32'hFFFF_FF80);
    send_access(OpSb, 16'h1235, 32'h0000_007F);
    send_access(OpSw, 16'hAAAA, 32'hFFFF_FFFF);
    send_access(OpSw, 16'h5554, 32'h0000_0000);
    send_access(OpLb, 16'h1234, 32'hFFFF_FFFF);
    send_access(OpLbu, 16'h1234, 32'h0000_0000);
    send_access(OpLb, 16'h1235, 32'h0000_0000);
    send_access(OpLh, 16'h7FFF, 32'h0000_0000);
    send_access(OpLhu, 16'h7FFF, 32'h0000_0000);
    send_access(OpLh, 16'h0002, 32'h0000_0000);
    send_access(OpLw, 16'hFFFE, 32'h0000_0000);
    send_access(OpLw, 16'hFFFF, 32'h0000_0000);
    send_access(OpLw, 16'hFFFC, 32'h0000_0000);
    send_access(OpLh, 16'hFFFF, 32'h0000_0000);
    send_access(OpLhu, 16'hFFFE, 32'h0000_0000);
    send_access(OpLw, 16'hAAAA, 32'h0000_0000);
    send_access(OpLw, 16'h5554, 32'h0000_0000);
    send_access(OpLb, 16'hAAAB, 32'h0000_0000);
    send_access(OpLbu, 16'h0000, 32'h0000_0000);
    wait_for_results();
  endtask

  task automatic test_streaming();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    run_random_accesses(450);
    wait_for_results();
  endtask

  task automatic test_sender_gaps();
    sender_idle_pct = 58;
    recv_stall_pct  = 0;
    run_random_accesses(450);
    wait_for_results();
  endtask

  task automatic test_receiver_stalls();
    sender_idle_pct = 0;
    recv_stall_pct  = 58;
    run_random_accesses(450);
    wait_for_results();
  endtask

  task automatic test_mixed_backpressure();
    sender_idle_pct = 26;
    recv_stall_pct  = 26;
    run_random_accesses(450);
    wait_for_results();
  endtask

  // The sender holds off until the pipeline is empty, then resumes.
  task automatic test_drain_pause();
    sender_idle_pct = 26;
    recv_stall_pct  = 26;
    run_random_accesses(50);
    wait_for_results();
    run_random_accesses(50);
    wait_for_results();
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    opcode_i     = OpLb;
    address_i    = '0;
    store_data_i = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_corners();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_backpressure();
    test_drain_pause();

    recv_stall_pct = 0;
    repeat (12) @(posedge clk_i);
    if (expected_reads.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", expected_reads.size());
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
